>>> rtl/stma_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stma_pkg: shared types and constants of the sparse triplet matrix adder
// Entry layout, word codes and the interface of the shared compare/add unit.
// ----------------------------------------------------------------------------
package stma_pkg;

  localparam int unsigned DEF_MAX_ENTRIES = 32;

  localparam int unsigned FUNC_W = 2;
  localparam int unsigned ROW_W  = 16;
  localparam int unsigned COL_W  = 16;
  localparam int unsigned VAL_W  = 32;

  // Codes of the func field of an input word.
  localparam logic [FUNC_W-1:0] FUNC_LOAD_A = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_B = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FINISH = 2'd2;

  // One stored triplet; {row, col} is the sort key.
  typedef struct packed {
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
  } entry_t;

  // Operation of the shared unit.
  typedef enum logic {
    ALU_MATCH,  // flag = keys equal, sum = value of lhs plus value of rhs
    ALU_ORDER   // flag = key of lhs greater than key of rhs
  } alu_op_e;

  typedef struct packed {
    logic                    flag;
    logic signed [VAL_W-1:0] sum;
  } alu_res_t;

endpackage
`default_nettype wire

>>> rtl/stma_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stma_if: word channels of the sparse triplet matrix adder
// Input channel carries load and finish words, output channel carries sums.
// ----------------------------------------------------------------------------
interface stma_in_if;
  logic                                valid;
  logic                                ready;
  logic [stma_pkg::FUNC_W-1:0]         func;
  logic [stma_pkg::ROW_W-1:0]          row;
  logic [stma_pkg::COL_W-1:0]          col;
  logic signed [stma_pkg::VAL_W-1:0]   value;

  modport source (output valid, output func, output row, output col, output value,
                  input ready);
  modport sink   (input valid, input func, input row, input col, input value,
                  output ready);
endinterface

interface stma_out_if;
  logic                                valid;
  logic                                ready;
  logic [stma_pkg::ROW_W-1:0]          out_row;
  logic [stma_pkg::COL_W-1:0]          out_col;
  logic signed [stma_pkg::VAL_W-1:0]   out_value;
  logic                                last_entry;
  logic                                empty_sum;
  logic                                overflowed;

  modport source (output valid, output out_row, output out_col, output out_value,
                  output last_entry, output empty_sum, output overflowed,
                  input ready);
  modport sink   (input valid, input out_row, input out_col, input out_value,
                  input last_entry, input empty_sum, input overflowed,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/stma_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stma_alu: shared key compare and value adder
// One 32-bit key comparator and one 32-bit wrapping adder used by merge and sort.
// ----------------------------------------------------------------------------
module stma_alu (
  input  stma_pkg::alu_op_e  op_i,
  input  stma_pkg::entry_t   lhs_i,
  input  stma_pkg::entry_t   rhs_i,
  output stma_pkg::alu_res_t res_o
);

  logic [stma_pkg::ROW_W+stma_pkg::COL_W-1:0] lhs_key;
  logic [stma_pkg::ROW_W+stma_pkg::COL_W-1:0] rhs_key;

  assign lhs_key = {lhs_i.row, lhs_i.col};
  assign rhs_key = {rhs_i.row, rhs_i.col};

  always_comb begin
    unique case (op_i)
      stma_pkg::ALU_MATCH: res_o.flag = (lhs_key == rhs_key);
      stma_pkg::ALU_ORDER: res_o.flag = (lhs_key > rhs_key);
      default:             res_o.flag = 1'b0;
    endcase
    // Two's complement add wraps at the value width.
    res_o.sum = lhs_i.value + rhs_i.value;
  end

endmodule
`default_nettype wire

>>> rtl/sparse_triplet_matrix_add.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_triplet_matrix_add: sum of two sparse matrices in triplet form
// Loads A and B entries, merges A into the sum list, sorts it and emits it.
// ----------------------------------------------------------------------------
//
//   channel   dir   words                              handshake
//   in_i      in    func, row, col, value              valid / ready
//   out_o     out   out_row, out_col, out_value,       valid / ready
//                   last_entry, empty_sum, overflowed
//
// A load word (A or B entry, or an unused func code) is taken without stalling.
// A finish word starts the sequencer and the input stays not ready until the
// last sum word has been placed in the output register. Merging reads each
// A entry and then the sum entries in order until a key matches, where it
// adds, or the list ends, where it appends; sorting is an exchange sort of
// the sum list; emitting reads one sum word per output register load. These
// steps share the one compare/add unit and the sum store's single read port.
// Reset clears only the counters, the drop flag, the state and the output
// valid; the stores are not cleared. A stalled output holds its word, and
// loads keep being taken while that word waits.
// ----------------------------------------------------------------------------
module sparse_triplet_matrix_add #(
  parameter int unsigned MAX_ENTRIES = stma_pkg::DEF_MAX_ENTRIES
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  stma_in_if.sink     in_i,
  stma_out_if.source  out_o
);

  // Sum list holds every B entry plus every unmatched A entry.
  localparam int unsigned SUM_DEPTH = 2 * MAX_ENTRIES;
  localparam int unsigned AAW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned SAW = $clog2(SUM_DEPTH);
  localparam int unsigned ACW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned SCW = $clog2(SUM_DEPTH + 1);

  // Sequencer states.
  localparam logic [3:0] ST_LOAD    = 4'd0;
  localparam logic [3:0] ST_M_ARD   = 4'd1;   // fetch next A entry
  localparam logic [3:0] ST_M_SRD   = 4'd2;   // fetch next sum entry to match
  localparam logic [3:0] ST_M_CMP   = 4'd3;   // compare keys, add on a hit
  localparam logic [3:0] ST_T_IRD   = 4'd4;   // fetch entry i of the sort
  localparam logic [3:0] ST_T_ILD   = 4'd5;   // hold entry i
  localparam logic [3:0] ST_T_JRD   = 4'd6;   // fetch entry j
  localparam logic [3:0] ST_T_CMP   = 4'd7;   // exchange when i is greater
  localparam logic [3:0] ST_E_RD    = 4'd8;   // fetch next word to emit
  localparam logic [3:0] ST_E_WT    = 4'd9;   // load the output register
  localparam logic [3:0] ST_E_EMPTY = 4'd10;  // emit the empty marker word

  logic [3:0]     state_q, state_d;
  logic [ACW-1:0] a_cnt_q, a_cnt_d;
  logic [ACW-1:0] b_cnt_q, b_cnt_d;
  logic [SCW-1:0] sum_cnt_q, sum_cnt_d;
  logic           drop_q, drop_d;
  logic [SCW-1:0] i_q, i_d;
  logic [SCW-1:0] j_q, j_d;
  logic [SCW-1:0] i_inc;

  stma_pkg::entry_t held_q, held_d;
  stma_pkg::entry_t in_entry;

  // A store: written while loading, read once per A entry during the merge.
  stma_pkg::entry_t a_mem [MAX_ENTRIES];
  logic             a_we;
  logic [AAW-1:0]   a_waddr;
  logic             a_re;
  stma_pkg::entry_t a_rdata_q;

  // Sum store: one write and one registered read per cycle.
  stma_pkg::entry_t s_mem [SUM_DEPTH];
  logic             s_we;
  logic [SAW-1:0]   s_waddr;
  stma_pkg::entry_t s_wdata;
  logic             s_re;
  logic [SAW-1:0]   s_raddr;
  stma_pkg::entry_t s_rdata_q;

  // Shared compare/add unit.
  stma_pkg::alu_op_e  alu_op;
  stma_pkg::entry_t   alu_lhs;
  stma_pkg::entry_t   alu_rhs;
  stma_pkg::alu_res_t alu_res;

  // Output register.
  logic             out_valid_q;
  logic             out_load;
  logic             slot_free;
  stma_pkg::entry_t out_entry_q, out_entry_d;
  logic             out_last_q, out_last_d;
  logic             out_empty_q, out_empty_d;
  logic             out_ovf_q, out_ovf_d;

  assign in_entry = '{row: in_i.row, col: in_i.col, value: in_i.value};
  assign i_inc    = i_q + SCW'(1);
  assign slot_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == ST_LOAD);

  stma_alu u_alu (
    .op_i  (alu_op),
    .lhs_i (alu_lhs),
    .rhs_i (alu_rhs),
    .res_o (alu_res)
  );

  // In the merge the sum entry is the left operand so that its key is kept;
  // in the sort the held entry i is compared against entry j.
  always_comb begin
    if (state_q == ST_M_CMP) begin
      alu_op  = stma_pkg::ALU_MATCH;
      alu_lhs = s_rdata_q;
      alu_rhs = a_rdata_q;
    end else begin
      alu_op  = stma_pkg::ALU_ORDER;
      alu_lhs = held_q;
      alu_rhs = s_rdata_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    a_cnt_d     = a_cnt_q;
    b_cnt_d     = b_cnt_q;
    sum_cnt_d   = sum_cnt_q;
    drop_d      = drop_q;
    i_d         = i_q;
    j_d         = j_q;
    held_d      = held_q;
    a_we        = 1'b0;
    a_waddr     = a_cnt_q[AAW-1:0];
    a_re        = 1'b0;
    s_we        = 1'b0;
    s_waddr     = sum_cnt_q[SAW-1:0];
    s_wdata     = in_entry;
    s_re        = 1'b0;
    s_raddr     = i_q[SAW-1:0];
    out_load    = 1'b0;
    out_entry_d = s_rdata_q;
    out_last_d  = 1'b0;
    out_empty_d = 1'b0;
    out_ovf_d   = drop_q;

    unique case (state_q)
      ST_LOAD: begin
        if (in_i.valid) begin
          unique case (in_i.func)
            stma_pkg::FUNC_LOAD_A: begin
              if (a_cnt_q < ACW'(MAX_ENTRIES)) begin
                a_we    = 1'b1;
                a_cnt_d = a_cnt_q + ACW'(1);
              end else begin
                drop_d = 1'b1;
              end
            end
            stma_pkg::FUNC_LOAD_B: begin
              if (b_cnt_q < ACW'(MAX_ENTRIES)) begin
                s_we      = 1'b1;
                sum_cnt_d = sum_cnt_q + SCW'(1);
                b_cnt_d   = b_cnt_q + ACW'(1);
              end else begin
                drop_d = 1'b1;
              end
            end
            stma_pkg::FUNC_FINISH: begin
              i_d     = '0;
              j_d     = '0;
              state_d = ST_M_ARD;
            end
            default: begin
            end
          endcase
        end
      end

      ST_M_ARD: begin
        j_d = '0;
        if (i_q == SCW'(a_cnt_q)) begin
          i_d     = '0;
          state_d = ST_T_IRD;
        end else begin
          a_re    = 1'b1;
          state_d = ST_M_SRD;
        end
      end

      ST_M_SRD: begin
        if (j_q == sum_cnt_q) begin
          // No entry with this key yet: append the A entry.
          s_we      = 1'b1;
          s_wdata   = a_rdata_q;
          sum_cnt_d = sum_cnt_q + SCW'(1);
          i_d       = i_inc;
          state_d   = ST_M_ARD;
        end else begin
          s_re    = 1'b1;
          s_raddr = j_q[SAW-1:0];
          state_d = ST_M_CMP;
        end
      end

      ST_M_CMP: begin
        if (alu_res.flag) begin
          s_we    = 1'b1;
          s_waddr = j_q[SAW-1:0];
          s_wdata = '{row: s_rdata_q.row, col: s_rdata_q.col, value: alu_res.sum};
          i_d     = i_inc;
          state_d = ST_M_ARD;
        end else begin
          j_d     = j_q + SCW'(1);
          state_d = ST_M_SRD;
        end
      end

      ST_T_IRD: begin
        if (i_inc >= sum_cnt_q) begin
          i_d     = '0;
          state_d = (sum_cnt_q == '0) ? ST_E_EMPTY : ST_E_RD;
        end else begin
          s_re    = 1'b1;
          j_d     = i_inc;
          state_d = ST_T_ILD;
        end
      end

      ST_T_ILD: begin
        held_d  = s_rdata_q;
        state_d = ST_T_JRD;
      end

      ST_T_JRD: begin
        if (j_q == sum_cnt_q) begin
          // Entry i is final for this pass.
          s_we    = 1'b1;
          s_waddr = i_q[SAW-1:0];
          s_wdata = held_q;
          i_d     = i_inc;
          state_d = ST_T_IRD;
        end else begin
          s_re    = 1'b1;
          s_raddr = j_q[SAW-1:0];
          state_d = ST_T_CMP;
        end
      end

      ST_T_CMP: begin
        if (alu_res.flag) begin
          s_we    = 1'b1;
          s_waddr = j_q[SAW-1:0];
          s_wdata = held_q;
          held_d  = s_rdata_q;
        end
        j_d     = j_q + SCW'(1);
        state_d = ST_T_JRD;
      end

      ST_E_RD: begin
        if (slot_free) begin
          s_re    = 1'b1;
          state_d = ST_E_WT;
        end
      end

      ST_E_WT: begin
        out_load   = 1'b1;
        out_last_d = (i_inc == sum_cnt_q);
        i_d        = i_inc;
        if (i_inc == sum_cnt_q) begin
          a_cnt_d   = '0;
          b_cnt_d   = '0;
          sum_cnt_d = '0;
          drop_d    = 1'b0;
          state_d   = ST_LOAD;
        end else begin
          state_d = ST_E_RD;
        end
      end

      ST_E_EMPTY: begin
        if (slot_free) begin
          out_load    = 1'b1;
          out_entry_d = '0;
          out_last_d  = 1'b1;
          out_empty_d = 1'b1;
          a_cnt_d     = '0;
          b_cnt_d     = '0;
          sum_cnt_d   = '0;
          drop_d      = 1'b0;
          state_d     = ST_LOAD;
        end
      end

      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      a_cnt_q     <= '0;
      b_cnt_q     <= '0;
      sum_cnt_q   <= '0;
      drop_q      <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      a_cnt_q   <= a_cnt_d;
      b_cnt_q   <= b_cnt_d;
      sum_cnt_q <= sum_cnt_d;
      drop_q    <= drop_d;
      i_q       <= i_d;
      j_q       <= j_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
    if (out_load) begin
      out_entry_q <= out_entry_d;
      out_last_q  <= out_last_d;
      out_empty_q <= out_empty_d;
      out_ovf_q   <= out_ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_we) begin
      a_mem[a_waddr] <= in_entry;
    end
    if (a_re) begin
      a_rdata_q <= a_mem[i_q[AAW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_we) begin
      s_mem[s_waddr] <= s_wdata;
    end
    if (s_re) begin
      s_rdata_q <= s_mem[s_raddr];
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_row    = out_entry_q.row;
  assign out_o.out_col    = out_entry_q.col;
  assign out_o.out_value  = out_entry_q.value;
  assign out_o.last_entry = out_last_q;
  assign out_o.empty_sum  = out_empty_q;
  assign out_o.overflowed = out_ovf_q;

  // The A count never passes the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_cnt_q <= ACW'(MAX_ENTRIES))
    else $error("A entry count beyond capacity");

  // The sum list never passes its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_cnt_q <= SCW'(SUM_DEPTH))
    else $error("sum entry count beyond store depth");

  // While loading, the sum list holds only B entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |-> (sum_cnt_q == SCW'(b_cnt_q)))
    else $error("sum count differs from B count while loading");

  // A finish word blocks the input on the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && (in_i.func == stma_pkg::FUNC_FINISH)) |=> !in_i.ready)
    else $error("input ready right after a finish word");

  // The empty marker word always closes its run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_empty_q) |-> out_last_q)
    else $error("empty word without last mark");

endmodule
`default_nettype wire

>>> test/tb_sparse_triplet_matrix_add.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sparse_triplet_matrix_add: self-checking bench of the triplet matrix adder
// A scripted opening and random load/finish problems drive the input channel.
// A behavioral adder predicts every sum word, and a monitor compares each
// accepted output word with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_sparse_triplet_matrix_add;
  import stma_pkg::*;

  // The block is built with its default capacity, and the predictor uses the same.
  localparam int unsigned CAPACITY     = DEF_MAX_ENTRIES;
  // The sum list can hold every B entry plus every unmatched A entry.
  localparam int unsigned SUM_SLOTS    = 2 * CAPACITY;
  // The fourth func code has no meaning, and the block must ignore it.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned RANDOM_WORDS = 110;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned PRINT_CAP    = 50;

  // One word on the input channel.
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [VAL_W-1:0]  value;
  } in_word_t;

  // One word on the output channel.
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [VAL_W-1:0] value;
    logic             last_entry;
    logic             empty_sum;
    logic             overflowed;
  } sum_word_t;

  // A row of the opening script. Where fixed is set, the row's single sum
  // word is written out by hand in fixed_sum. Otherwise the predictor decides.
  typedef struct packed {
    in_word_t  word;
    logic      fixed;
    sum_word_t fixed_sum;
  } script_row_t;

  localparam sum_word_t NO_SUM    = '0;
  localparam sum_word_t EMPTY_SUM = '{16'h0000, 16'h0000, 32'h0000_0000, 1'b1, 1'b1, 1'b0};

  // The opening script covers these cases:
  //  - a finish right after reset, and a finish after an ignored word. Both
  //    give the marked empty word. The finish words carry junk indexes, which
  //    the block must ignore.
  //  - value wrap in both directions at the extreme corner keys.
  //  - two A entries at one key, where the second adds onto the first once it
  //    has been appended, and the zero sum that results is kept.
  //  - duplicate B keys, where the A entry adds only onto the first of them.
  //  - row order against column order, an ignored word between loads, and a
  //    single-entry sum.
  //  - alternating bit patterns on every field.
  localparam script_row_t OPENING[22] = '{
    '{'{FUNC_FINISH, 16'h1234, 16'h5678, 32'h9ABC_DEF0}, 1'b1, EMPTY_SUM},
    '{'{FUNC_UNUSED, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF}, 1'b0, NO_SUM},
    '{'{FUNC_FINISH, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF}, 1'b1, EMPTY_SUM},
    '{'{FUNC_LOAD_B, 16'h0000, 16'h0000, 32'h7FFF_FFFF}, 1'b0, NO_SUM},
    '{'{FUNC_LOAD_A, 16'h0000, 16'h0000, 32'h0000_0001}, 1'b0, NO_SUM},
    '{'{FUNC_LOAD_B, 16'hFFFF, 16'hFFFF, 32'h8000_0000}, 1'b0, NO_SUM},
    '{'{FUNC_LOAD_A, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF}, 1'b0, NO_SUM},
    '{'{FUNC_LOAD_A, 16'h0001, 16'h0002, 32'h0000_0005}, 1'b0, NO_SUM},
    '{'{FUNC_LOAD_A, 16'h0001, 16'h0002, 32'hFFFF_FFFB}, 1'b0, NO_SUM},
    '{'{FUNC_LOAD_B, 16'h0003, 16'h0003, 32'h0000_000A}, 1'b0, NO_SUM},
    '{'{FUNC_LOAD_B, 16'h0003, 16'h0003, 32'h0000_0014}, 1'b0, NO_SUM},
    '{'{FUNC_LOAD_A, 16'h0003, 16'h0003, 32'h0000_0001}, 1'b0, NO_SUM},
    '{'{FUNC_UNUSED, 16'h0003, 16'h0003, 32'h0000_0064}, 1'b0, NO_SUM},
    '{'{FUNC_LOAD_B, 16'h0002, 16'h0000, 32'h0000_0007}, 1'b0, NO_SUM},
    '{'{FUNC_LOAD_B, 16'h0000, 16'hFFFF, 32'h0000_0009}, 1'b0, NO_SUM},
    '{'{FUNC_LOAD_A, 16'h0002, 16'h0000, 32'h8000_0000}, 1'b0, NO_SUM},
    '{'{FUNC_FINISH, 16'h0000, 16'h0000, 32'h0000_0000}, 1'b0, NO_SUM},
    '{'{FUNC_LOAD_A, 16'h0005, 16'h0005, 32'h0000_0007}, 1'b0, NO_SUM},
    '{'{FUNC_FINISH, 16'h0000, 16'h0000, 32'h0000_0000}, 1'b1,
      '{16'h0005, 16'h0005, 32'h0000_0007, 1'b1, 1'b0, 1'b0}},
    '{'{FUNC_LOAD_B, 16'hAAAA, 16'h5555, 32'hAAAA_AAAA}, 1'b0, NO_SUM},
    '{'{FUNC_LOAD_A, 16'h5555, 16'hAAAA, 32'h5555_5555}, 1'b0, NO_SUM},
    '{'{FUNC_FINISH, 16'h0000, 16'h0000, 32'h0000_0000}, 1'b0, NO_SUM}
  };

  logic clk_i;
  logic rst_ni;

  stma_in_if  in_if ();
  stma_out_if out_if ();

  sparse_triplet_matrix_add #(
    .MAX_ENTRIES(CAPACITY)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // 10 ns clock.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Predictor state. It mirrors what the block holds between finish words.
  entry_t      a_list [CAPACITY];
  int unsigned a_held;
  entry_t      sum_list [SUM_SLOTS];
  int unsigned sum_held;
  int unsigned b_held;
  logic        drop_seen;
  sum_word_t   fresh_sums [$];   // Sum words caused by the latest word.
  sum_word_t   sum_words_due [$]; // Predicted sum words not yet seen.

  // Idle rates in percent. The main sequence changes them as it goes.
  int unsigned send_gap_pct;
  int unsigned stall_pct;

  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned sum_words_seen;
  int unsigned finish_count;
  int unsigned random_words;
  int unsigned dropped_runs;
  sum_word_t   head_sum;

  // Applies one accepted input word to the predictor's state. A finish word
  // leaves the sum words that it causes in fresh_sums.
  function automatic void predict_word(input in_word_t w);
    entry_t      incoming;
    entry_t      swap;
    int unsigned i;
    int unsigned j;
    logic        hit;
    fresh_sums.delete();
    incoming = '{w.row, w.col, w.value};
    case (w.func)
      FUNC_LOAD_A: begin
        if (a_held < CAPACITY) begin
          a_list[a_held] = incoming;
          a_held++;
        end else begin
          drop_seen = 1'b1;
        end
      end
      FUNC_LOAD_B: begin
        // B entries go straight into the sum list.
        if (b_held < CAPACITY && sum_held < SUM_SLOTS) begin
          sum_list[sum_held] = incoming;
          sum_held++;
          b_held++;
        end else begin
          drop_seen = 1'b1;
        end
      end
      FUNC_FINISH: begin
        // Merge: each A entry, in load order, adds onto the first sum entry
        // with its key, or is appended. Appended entries can be hit by later
        // A entries.
        for (i = 0; i < a_held; i++) begin
          hit = 1'b0;
          for (j = 0; j < sum_held; j++) begin
            if (!hit && sum_list[j].row == a_list[i].row
                && sum_list[j].col == a_list[i].col) begin
              sum_list[j].value = sum_list[j].value + a_list[i].value;
              hit = 1'b1;
            end
          end
          if (!hit && sum_held < SUM_SLOTS) begin
            sum_list[sum_held] = a_list[i];
            sum_held++;
          end
        end
        // Exchange sort on the {row, col} key. This order is not stable, and
        // duplicate B keys come out exactly as this loop leaves them.
        for (i = 0; i + 1 < sum_held; i++) begin
          for (j = i + 1; j < sum_held; j++) begin
            if ({sum_list[i].row, sum_list[i].col} > {sum_list[j].row, sum_list[j].col}) begin
              swap        = sum_list[i];
              sum_list[i] = sum_list[j];
              sum_list[j] = swap;
            end
          end
        end
        if (sum_held == 0) begin
          fresh_sums.push_back('{16'h0000, 16'h0000, 32'h0000_0000, 1'b1, 1'b1, drop_seen});
        end else begin
          for (i = 0; i < sum_held; i++) begin
            fresh_sums.push_back('{sum_list[i].row, sum_list[i].col, sum_list[i].value,
                                   (i + 1 == sum_held), 1'b0, drop_seen});
          end
        end
        if (drop_seen) begin
          dropped_runs++;
        end
        a_held    = 0;
        sum_held  = 0;
        b_held    = 0;
        drop_seen = 1'b0;
      end
      default: begin
        // The unused code changes nothing.
      end
    endcase
  endfunction

  // Prints one line for a mismatch and counts it. The count always rises,
  // but printing stops after the first PRINT_CAP lines to keep the log short.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < PRINT_CAP) begin
      $display("MISMATCH sum word %0d: %s got %h want %h", sum_words_seen, what, got, want);
    end
    mismatch_count++;
  endtask

  // Presents one word, possibly after some idle cycles, and holds it until
  // the block takes it. The predictor then runs on the accepted word.
  task automatic send_word(input in_word_t w, input logic fixed, input sum_word_t fixed_sum);
    while (send_gap_pct != 0 && $urandom_range(1, 100) <= send_gap_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.func  <= w.func;
    in_if.row   <= w.row;
    in_if.col   <= w.col;
    in_if.value <= w.value;
    @(posedge clk_i);
    while (!in_if.ready) begin
      @(posedge clk_i);
    end
    predict_word(w);
    if (fixed) begin
      sum_words_due.push_back(fixed_sum);
    end else begin
      foreach (fresh_sums[k]) begin
        sum_words_due.push_back(fresh_sums[k]);
      end
    end
    if (w.func == FUNC_FINISH) begin
      finish_count++;
    end
  endtask

  // Index picker. Narrow picks cluster on a few keys so that A entries hit
  // sum entries and B keys repeat. Wide picks spread over the whole range.
  function automatic logic [15:0] pick_index(input logic wide);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (wide || roll < 25) begin
      return 16'($urandom);
    end
    if (roll < 40) begin
      return roll[0] ? 16'hFFFF : 16'h0000;
    end
    return 16'($urandom_range(0, 3));
  endfunction

  // Value picker. It mixes the wrap corners, small values of both signs that
  // make zero sums likely, and full random words.
  function automatic logic [31:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) begin
      case ($urandom_range(0, 3))
        0:       return 32'h7FFF_FFFF;
        1:       return 32'h8000_0000;
        2:       return 32'hFFFF_FFFF;
        default: return 32'h0000_0000;
      endcase
    end
    if (roll < 35) begin
      return 32'($urandom_range(0, 20)) - 32'd10;
    end
    return 32'($urandom);
  endfunction

  // One random problem. It loads n_a A entries and n_b B entries in random
  // interleaving, with an ignored word now and then, and then sends a finish.
  // Ignored words do not count toward the random total.
  task automatic run_problem(input int unsigned n_a, input int unsigned n_b,
                             input logic wide);
    in_word_t    w;
    int unsigned left_a;
    int unsigned left_b;
    left_a = n_a;
    left_b = n_b;
    while (left_a + left_b != 0) begin
      if ($urandom_range(0, 11) == 0) begin
        w = '{FUNC_UNUSED, 16'($urandom), 16'($urandom), 32'($urandom)};
        send_word(w, 1'b0, NO_SUM);
      end
      if (left_b == 0 || (left_a != 0 && $urandom_range(0, 1) == 0)) begin
        w.func = FUNC_LOAD_A;
        left_a--;
      end else begin
        w.func = FUNC_LOAD_B;
        left_b--;
      end
      w.row   = pick_index(wide);
      w.col   = pick_index(wide);
      w.value = pick_value();
      send_word(w, 1'b0, NO_SUM);
      random_words++;
    end
    // The finish carries random junk in the fields that it must ignore.
    w = '{FUNC_FINISH, 16'($urandom), 16'($urandom), 32'($urandom)};
    send_word(w, 1'b0, NO_SUM);
    random_words++;
  endtask

  // Output ready. When stall_pct is zero, ready stays high on every cycle.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= ($urandom_range(1, 100) > stall_pct);
    end
  end

  // Output monitor. It compares every accepted sum word with the oldest
  // prediction, field by field.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (sum_words_due.size() == 0) begin
        report_mismatch("sum word with nothing due, row/col",
                        {out_if.out_row, out_if.out_col}, 32'h0);
      end else begin
        head_sum = sum_words_due.pop_front();
        if (out_if.out_row !== head_sum.row) begin
          report_mismatch("out_row", 32'(out_if.out_row), 32'(head_sum.row));
        end
        if (out_if.out_col !== head_sum.col) begin
          report_mismatch("out_col", 32'(out_if.out_col), 32'(head_sum.col));
        end
        if (out_if.out_value !== head_sum.value) begin
          report_mismatch("out_value", out_if.out_value, head_sum.value);
        end
        if (out_if.last_entry !== head_sum.last_entry) begin
          report_mismatch("last_entry", 32'(out_if.last_entry), 32'(head_sum.last_entry));
        end
        if (out_if.empty_sum !== head_sum.empty_sum) begin
          report_mismatch("empty_sum", 32'(out_if.empty_sum), 32'(head_sum.empty_sum));
        end
        if (out_if.overflowed !== head_sum.overflowed) begin
          report_mismatch("overflowed", 32'(out_if.overflowed), 32'(head_sum.overflowed));
        end
      end
      sum_words_seen++;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Watchdog. It ends the run as failed once cycle_count reaches CYCLE_LIMIT.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("sparse_triplet_matrix_add verification failed");
    $finish;
  end

  // Main sequence: reset, the opening script, random problems, then drain.
  initial begin
    int unsigned problem;
    cycle_count    = 0;
    mismatch_count = 0;
    sum_words_seen = 0;
    finish_count   = 0;
    random_words   = 0;
    dropped_runs   = 0;
    send_gap_pct   = 0;
    stall_pct      = 0;
    a_held         = 0;
    sum_held       = 0;
    b_held         = 0;
    drop_seen      = 1'b0;
    rst_ni         <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.func     <= FUNC_LOAD_A;
    in_if.row      <= '0;
    in_if.col      <= '0;
    in_if.value    <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (OPENING[r]) begin
      send_word(OPENING[r].word, OPENING[r].fixed, OPENING[r].fixed_sum);
    end

    // The idle mode rotates with each problem, so that gaps and stalls fall
    // on loading, on the merge and sort, and on the emission. Problem 2 fills
    // both stores with wide keys to get the longest sum list, and then
    // overflows A. Problem 3 overflows B. The rest are small problems on
    // clustered keys, now and then an empty one.
    problem = 0;
    while (random_words < RANDOM_WORDS) begin
      case (problem % 4)
        0: begin
          send_gap_pct = 0;
          stall_pct    = 0;
        end
        1: begin
          send_gap_pct = 65;
          stall_pct    = 0;
        end
        2: begin
          send_gap_pct = 0;
          stall_pct    = 65;
        end
        default: begin
          send_gap_pct = 15;
          stall_pct    = 15;
        end
      endcase
      if (problem == 2) begin
        run_problem($urandom_range(CAPACITY + 1, CAPACITY + 4), CAPACITY, 1'b1);
      end else if (problem == 3) begin
        run_problem($urandom_range(0, 3), $urandom_range(CAPACITY + 1, CAPACITY + 4), 1'b1);
      end else if ($urandom_range(0, 7) == 0) begin
        run_problem(0, 0, 1'b0);
      end else begin
        run_problem($urandom_range(0, 6), $urandom_range(0, 6), 1'b0);
      end
      problem++;
    end
    in_if.valid <= 1'b0;
    stall_pct    = 0;

    while (sum_words_due.size() != 0) begin
      @(posedge clk_i);
    end
    // Give any stray sum word time to show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d random load/finish words over %0d problems, %0d finishes in all",
             random_words, problem, finish_count);
    $display("%0d sum words checked, %0d finishes with dropped entries, %0d mismatches",
             sum_words_seen, dropped_runs, mismatch_count);
    if (mismatch_count == 0) begin
      $display("sparse_triplet_matrix_add verification clean");
    end else begin
      $display("sparse_triplet_matrix_add verification failed");
    end
    $finish;
  end

endmodule
